### sv/gyro_angle_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle frame parser
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GYRO_ANGLE_FRAME_PARSER_TOP_MACROS_SVH
`define GYRO_ANGLE_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GAFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gafp check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define GAFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gafp check failed");

`endif

### sv/gafp_pkg.sv
// ----------------------------------------------------------------------------
// gafp_pkg
// Constants and types shared by the angle frame parser modules.
// ----------------------------------------------------------------------------
package gafp_pkg;

  localparam int unsigned CountW = 5;

  localparam logic [CountW-1:0] BURST_LEN       = 5'd22;
  localparam logic [CountW-1:0] COUNT_SAT       = 5'd23;
  localparam logic [CountW-1:0] POS_RATE_HDR    = 5'd0;
  localparam logic [CountW-1:0] POS_RATE_TYPE   = 5'd1;
  localparam logic [CountW-1:0] POS_RATE_LAST   = 5'd9;
  localparam logic [CountW-1:0] POS_RATE_SUM    = 5'd10;
  localparam logic [CountW-1:0] POS_ANGLE_HDR   = 5'd11;
  localparam logic [CountW-1:0] POS_ANGLE_TYPE  = 5'd12;
  localparam logic [CountW-1:0] POS_ANGLE_LO    = 5'd17;
  localparam logic [CountW-1:0] POS_ANGLE_HI    = 5'd18;
  localparam logic [CountW-1:0] POS_ANGLE_LAST  = 5'd20;

  localparam logic [7:0] RATE_TYPE    = 8'h52;
  localparam logic [7:0] ANGLE_TYPE   = 8'h53;
  localparam logic [7:0] HEADER_RESET = 8'h55;
  localparam logic [7:0] DEG_SCALE    = 8'd180;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] raw;
  } burst_res_t;

endpackage

### sv/gafp_burst_check.sv
// ----------------------------------------------------------------------------
// gafp_burst_check
// Tracks one burst: byte position, packet checks, running sums and the
// captured angle bytes, and flags a good burst on its last byte.
// ----------------------------------------------------------------------------
module gafp_burst_check
  import gafp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] header_i,
  input  byte_word_t word_i,
  output burst_res_t res_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        rate_sum_q, rate_sum_d;
  logic [7:0]        angle_sum_q, angle_sum_d;
  logic              ok_q, ok_d;
  logic [7:0]        lo_q, lo_d;
  logic [7:0]        hi_q, hi_d;

  always_comb begin
    count_d     = count_q;
    rate_sum_d  = rate_sum_q;
    angle_sum_d = angle_sum_q;
    ok_d        = ok_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_o.ok    = 1'b0;
    res_o.raw   = {hi_q, lo_q};
    if (word_i.valid) begin
      if (count_q < BURST_LEN) begin
        if ((count_q == POS_RATE_HDR || count_q == POS_ANGLE_HDR) &&
            word_i.data != header_i) begin
          ok_d = 1'b0;
        end
        if (count_q == POS_RATE_TYPE && word_i.data != RATE_TYPE) begin
          ok_d = 1'b0;
        end
        if (count_q == POS_ANGLE_TYPE && word_i.data != ANGLE_TYPE) begin
          ok_d = 1'b0;
        end
        if (count_q <= POS_RATE_LAST) begin
          rate_sum_d = rate_sum_q + word_i.data;
        end else if (count_q == POS_RATE_SUM) begin
          if (word_i.data != rate_sum_q) begin
            ok_d = 1'b0;
          end
        end else if (count_q <= POS_ANGLE_LAST) begin
          angle_sum_d = angle_sum_q + word_i.data;
          if (count_q == POS_ANGLE_LO) begin
            lo_d = word_i.data;
          end else if (count_q == POS_ANGLE_HI) begin
            hi_d = word_i.data;
          end
        end else if (word_i.data != angle_sum_q) begin
          ok_d = 1'b0;
        end
      end
      if (count_q < COUNT_SAT) begin
        count_d = count_q + 5'd1;
      end
      res_o.ok  = word_i.last && (count_d == BURST_LEN) && ok_d;
      res_o.raw = {hi_d, lo_d};
      if (word_i.last) begin
        count_d     = '0;
        rate_sum_d  = '0;
        angle_sum_d = '0;
        ok_d        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rate_sum_q  <= '0;
      angle_sum_q <= '0;
      ok_q        <= 1'b1;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      count_q     <= count_d;
      rate_sum_q  <= rate_sum_d;
      angle_sum_q <= angle_sum_d;
      ok_q        <= ok_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
    end
  end

endmodule

### sv/gyro_angle_frame_parser_top.sv
// ----------------------------------------------------------------------------
// gyro_angle_frame_parser_top
// Checks two-packet sensor bursts and returns the yaw angle of good ones.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   data_byte_i, end_of_burst_i
//   out      source     out_valid_o/out_ready_i angle_raw_o, angle_degrees_q7_o
//   cfg      sink       cfg_we_i                cfg_wdata_i (header byte)
//
// One word per cycle is taken while in_ready_o is high. A word waits in the
// input register; as it leaves, the burst checker updates, and a burst's
// result reaches the output register as its last word leaves. Both registers
// advance together unless a result waits unread; then the input register
// holds and in_ready_o drops once it is full too. Reset clears the burst
// state and sets the header to 55h.
// ----------------------------------------------------------------------------
`include "gyro_angle_frame_parser_top_macros.svh"

module gyro_angle_frame_parser_top
  import gafp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_burst_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] angle_raw_o,
  output logic signed [15:0] angle_degrees_q7_o
);

  logic [7:0]         header_q;
  logic               s1_valid_q;
  logic [7:0]         s1_data_q;
  logic               s1_last_q;
  logic               out_free;
  logic               s1_fire;
  byte_word_t         chk_word;
  burst_res_t         chk_res;
  logic signed [24:0] deg_prod;
  logic               out_valid_q;
  logic signed [15:0] raw_q;
  logic signed [15:0] deg_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
    end else if (cfg_we_i) begin
      header_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= end_of_burst_i;
    end
  end

  assign chk_word.valid = s1_fire;
  assign chk_word.data  = s1_data_q;
  assign chk_word.last  = s1_last_q;

  gafp_burst_check u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .header_i (header_q),
    .word_i   (chk_word),
    .res_o    (chk_res)
  );

  // Floor of raw * 180 / 256 is an arithmetic shift of the product.
  assign deg_prod = $signed({{9{chk_res.raw[15]}}, chk_res.raw}) *
                    $signed({17'd0, DEG_SCALE});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= chk_res.ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && chk_res.ok) begin
      raw_q <= $signed(chk_res.raw);
      deg_q <= deg_prod[23:8];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign angle_raw_o        = raw_q;
  assign angle_degrees_q7_o = deg_q;

  `GAFP_ASSERT_IMPL(a_ready_low_full, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i)
  `GAFP_ASSERT_IMPL(a_sign_match, out_valid_o, angle_degrees_q7_o[15] == angle_raw_o[15])
  `GAFP_ASSERT_NEXT(a_no_result, out_free && !(s1_valid_q && s1_last_q), !out_valid_o)

endmodule

### bench/gyro_angle_frame_parser_top_tb.sv
// ----------------------------------------------------------------------------
// gyro_angle_frame_parser_top_tb
// Self-checking bench for the angle frame parser. Sensor bursts are built
// byte by byte. Some are good and some are cut short, run long, have one byte
// spoiled or are pure noise. A behavioral model of the parser predicts each
// yaw result, and every word on the output channel is compared with it. Both
// channels idle and stall at random. A long receiver hold makes the block fill
// up and push back on its input. The header register is changed between
// bursts, and once in the middle of a burst.
// ----------------------------------------------------------------------------
module gyro_angle_frame_parser_top_tb;
  import gafp_pkg::*;

  localparam int RandomBytes = 1100;
  localparam int LongHold    = 300;
  localparam int DrainLimit  = 2000;
  localparam int PipeSettle  = 6;
  localparam int Watchdog    = 400000;

  typedef enum logic [2:0] {
    SHAPE_GOOD,
    SHAPE_RESIZE,
    SHAPE_SPOIL,
    SHAPE_SPLIT,
    SHAPE_NOISE
  } shape_e;

  typedef struct packed {
    logic signed [15:0] raw;
    logic signed [15:0] deg;
  } yaw_t;

  typedef struct packed {
    shape_e             shape;
    int                 arg;
    logic               set_cfg;
    logic [7:0]         cfg;
    logic [15:0]        yaw;
    logic               typed;
    logic signed [15:0] t_raw;
    logic signed [15:0] t_deg;
  } probe_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [7:0]         cfg_wdata_i    = 8'h00;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i    = 8'h00;
  logic               end_of_burst_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic signed [15:0] angle_raw_o;
  logic signed [15:0] angle_degrees_q7_o;

  logic [7:0]        hdr_reg   = HEADER_RESET;
  logic [CountW-1:0] pos_cnt   = '0;
  logic [7:0]        rate_acc  = 8'h00;
  logic [7:0]        angle_acc = 8'h00;
  logic              burst_ok  = 1'b1;
  logic [7:0]        yaw_lo    = 8'h00;
  logic [7:0]        yaw_hi    = 8'h00;

  yaw_t       pending_yaw[$];
  logic [7:0] frame_buf[$];
  int         fault_count = 0;
  int         bytes_sent  = 0;
  bit         steady      = 1'b0;
  bit         hold_req    = 1'b0;
  bit         typed_on    = 1'b0;
  yaw_t       typed_res;

  logic [15:0] corner_yaw[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};

  probe_t probes[20] = '{
    '{SHAPE_GOOD,   22, 1'b0, 8'h00, 16'h0000, 1'b1, 16'sd0,     16'sd0},
    '{SHAPE_GOOD,   22, 1'b0, 8'h00, 16'h7FFF, 1'b1, 16'sd32767, 16'sd23039},
    '{SHAPE_GOOD,   22, 1'b0, 8'h00, 16'h8000, 1'b1, 16'sh8000,  -16'sd23040},
    '{SHAPE_GOOD,   22, 1'b0, 8'h00, 16'hFFFF, 1'b1, -16'sd1,    -16'sd1},
    '{SHAPE_RESIZE, 21, 1'b0, 8'h00, 16'h1111, 1'b0, 16'sd0,     16'sd0},
    '{SHAPE_RESIZE, 1,  1'b0, 8'h00, 16'h2222, 1'b0, 16'sd0,     16'sd0},
    '{SHAPE_RESIZE, 23, 1'b0, 8'h00, 16'h3333, 1'b0, 16'sd0,     16'sd0},
    '{SHAPE_RESIZE, 30, 1'b0, 8'h00, 16'h4444, 1'b0, 16'sd0,     16'sd0},
    '{SHAPE_SPOIL,  int'(POS_RATE_HDR),   1'b0, 8'h00, 16'h5555, 1'b0, 16'sd0, 16'sd0},
    '{SHAPE_SPOIL,  int'(POS_ANGLE_HDR),  1'b0, 8'h00, 16'h6666, 1'b0, 16'sd0, 16'sd0},
    '{SHAPE_SPOIL,  int'(POS_RATE_TYPE),  1'b0, 8'h00, 16'h7777, 1'b0, 16'sd0, 16'sd0},
    '{SHAPE_SPOIL,  int'(POS_ANGLE_TYPE), 1'b0, 8'h00, 16'h8888, 1'b0, 16'sd0, 16'sd0},
    '{SHAPE_SPOIL,  int'(POS_RATE_SUM),   1'b0, 8'h00, 16'h9999, 1'b0, 16'sd0, 16'sd0},
    '{SHAPE_SPOIL,  int'(BURST_LEN) - 1,  1'b0, 8'h00, 16'hAAAA, 1'b0, 16'sd0, 16'sd0},
    '{SHAPE_GOOD,   22, 1'b1, 8'h00, 16'h1234, 1'b0, 16'sd0,     16'sd0},
    '{SHAPE_GOOD,   22, 1'b1, 8'hFF, 16'h0001, 1'b1, 16'sd1,     16'sd0},
    '{SHAPE_SPLIT,  0,  1'b1, 8'h3C, 16'hA5C3, 1'b0, 16'sd0,     16'sd0},
    '{SHAPE_GOOD,   22, 1'b1, 8'h55, 16'h4000, 1'b1, 16'sd16384, 16'sd11520},
    '{SHAPE_NOISE,  22, 1'b0, 8'h00, 16'h0000, 1'b0, 16'sd0,     16'sd0},
    '{SHAPE_GOOD,   22, 1'b0, 8'h00, 16'h0080, 1'b0, 16'sd0,     16'sd0}
  };

  gyro_angle_frame_parser_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .end_of_burst_i    (end_of_burst_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .angle_raw_o       (angle_raw_o),
    .angle_degrees_q7_o(angle_degrees_q7_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void flag_error(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic bit track_byte(input logic [7:0] d, input logic eob, output yaw_t res);
    int scaled;
    bit hit;
    hit = 1'b0;
    res = '0;
    if (pos_cnt < BURST_LEN) begin
      if ((pos_cnt == POS_RATE_HDR || pos_cnt == POS_ANGLE_HDR) && d != hdr_reg) burst_ok = 1'b0;
      if (pos_cnt == POS_RATE_TYPE && d != RATE_TYPE) burst_ok = 1'b0;
      if (pos_cnt == POS_ANGLE_TYPE && d != ANGLE_TYPE) burst_ok = 1'b0;
      if (pos_cnt <= POS_RATE_LAST) begin
        rate_acc = rate_acc + d;
      end else if (pos_cnt == POS_RATE_SUM) begin
        if (d != rate_acc) burst_ok = 1'b0;
      end else if (pos_cnt <= POS_ANGLE_LAST) begin
        angle_acc = angle_acc + d;
        if (pos_cnt == POS_ANGLE_LO) yaw_lo = d;
        else if (pos_cnt == POS_ANGLE_HI) yaw_hi = d;
      end else if (d != angle_acc) begin
        burst_ok = 1'b0;
      end
    end
    if (pos_cnt < COUNT_SAT) pos_cnt = pos_cnt + 5'd1;
    if (eob) begin
      if (pos_cnt == BURST_LEN && burst_ok) begin
        res.raw = {yaw_hi, yaw_lo};
        scaled  = res.raw * int'(DEG_SCALE);
        res.deg = 16'(scaled >>> 8);
        hit     = 1'b1;
      end
      pos_cnt   = '0;
      rate_acc  = 8'h00;
      angle_acc = 8'h00;
      burst_ok  = 1'b1;
    end
    return hit;
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic eob);
    int gap;
    yaw_t res;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= d;
    end_of_burst_i <= eob;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (track_byte(d, eob, res)) pending_yaw.push_back(typed_on ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic send_span(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic fill_burst(input shape_e shape, input int arg, input logic [7:0] hdr_b,
                            input logic [15:0] yaw);
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    logic [7:0] b;
    frame_buf.delete();
    sum_a = 8'h00;
    sum_b = 8'h00;
    for (int i = 0; i < int'(BURST_LEN); i++) begin
      if (i == POS_RATE_HDR) b = hdr_reg;
      else if (i == POS_ANGLE_HDR) b = hdr_b;
      else if (i == POS_RATE_TYPE) b = RATE_TYPE;
      else if (i == POS_ANGLE_TYPE) b = ANGLE_TYPE;
      else if (i == POS_ANGLE_LO) b = yaw[7:0];
      else if (i == POS_ANGLE_HI) b = yaw[15:8];
      else if (i == POS_RATE_SUM) b = sum_a;
      else if (i == BURST_LEN - 1) b = sum_b;
      else b = 8'($urandom);
      if (i < POS_RATE_SUM) sum_a = sum_a + b;
      else if (i > POS_RATE_SUM && i < BURST_LEN - 1) sum_b = sum_b + b;
      frame_buf.push_back(b);
    end
    case (shape)
      SHAPE_RESIZE: begin
        while (frame_buf.size() > arg) void'(frame_buf.pop_back());
        while (frame_buf.size() < arg) frame_buf.push_back(8'($urandom));
      end
      SHAPE_SPOIL: begin
        frame_buf[arg] = frame_buf[arg] ^ 8'($urandom_range(1, 255));
      end
      SHAPE_NOISE: begin
        frame_buf.delete();
        repeat (arg) frame_buf.push_back(8'($urandom));
      end
      default: begin
      end
    endcase
  endtask

  task automatic run_burst(input shape_e shape, input int arg, input logic [15:0] yaw);
    fill_burst(shape, arg, hdr_reg, yaw);
    send_span(0, frame_buf.size() - 1);
  endtask

  task automatic wait_idle();
    int n;
    in_valid_i <= 1'b0;
    n = 0;
    while (pending_yaw.size() != 0 && n < DrainLimit) begin
      @(negedge clk_i);
      n++;
    end
    repeat (PipeSettle) @(negedge clk_i);
  endtask

  task automatic set_header(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_reg = v;
  endtask

  initial begin : result_sink
    int stall;
    yaw_t want;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_yaw.size() == 0) begin
        flag_error($sformatf("unexpected word: raw %0d deg %0d",
                             angle_raw_o, angle_degrees_q7_o));
      end else begin
        want = pending_yaw.pop_front();
        if (angle_raw_o !== want.raw) begin
          flag_error($sformatf("angle_raw: expected %0d, got %0d", want.raw, angle_raw_o));
        end
        if (angle_degrees_q7_o !== want.deg) begin
          flag_error($sformatf("angle_degrees_q7: expected %0d, got %0d",
                               want.deg, angle_degrees_q7_o));
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    probe_t p;
    logic [15:0] yaw;
    int burst_no;
    int r;
    int len;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(probes); i++) begin
      p = probes[i];
      steady = (i % 3 == 2);
      typed_on = p.typed;
      typed_res.raw = p.t_raw;
      typed_res.deg = p.t_deg;
      if (p.set_cfg && p.shape != SHAPE_SPLIT) begin
        wait_idle();
        set_header(p.cfg);
      end
      if (p.shape == SHAPE_SPLIT) begin
        fill_burst(SHAPE_GOOD, 0, p.cfg, p.yaw);
        send_span(0, int'(POS_RATE_SUM));
        wait_idle();
        set_header(p.cfg);
        send_span(int'(POS_ANGLE_HDR), frame_buf.size() - 1);
      end else begin
        run_burst(p.shape, p.arg, p.yaw);
      end
      typed_on = 1'b0;
    end
    wait_idle();

    bytes_sent = 0;
    burst_no = 0;
    while (bytes_sent < RandomBytes) begin
      if (burst_no % 16 == 15) begin
        wait_idle();
        r = $urandom_range(0, 3);
        set_header(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom));
      end
      if (burst_no == 20) hold_req = 1'b1;
      steady = ($urandom_range(0, 5) == 0);
      yaw = ($urandom_range(0, 7) == 0) ? corner_yaw[$urandom_range(0, 3)] : 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        run_burst(SHAPE_GOOD, 0, yaw);
      end else if (r < 80) begin
        run_burst(SHAPE_SPOIL, $urandom_range(0, int'(BURST_LEN) - 1), yaw);
      end else if (r < 90) begin
        len = $urandom_range(1, 30);
        if (len == BURST_LEN) len++;
        run_burst(SHAPE_RESIZE, len, yaw);
      end else begin
        run_burst(SHAPE_NOISE, $urandom_range(1, 30), yaw);
      end
      burst_no++;
    end

    wait_idle();
    if (pending_yaw.size() != 0) begin
      flag_error($sformatf("%0d expected words never arrived", pending_yaw.size()));
    end
    if (fault_count == 0) begin
      $display("gyro_angle_frame_parser_top_tb OK");
    end else begin
      $display("gyro_angle_frame_parser_top_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(Watchdog);
    $display("gyro_angle_frame_parser_top_tb NOT OK");
    $finish;
  end

endmodule
